// ----- sv/hup_pkg.sv -----
// ----------------------------------------------------------------------------
// hup_pkg: shared definitions of the hex card-number frame parser
// Frame symbols, window geometry, the per-cell status record and the
// ASCII hex digit decoder used by every cell of the byte window.
// ----------------------------------------------------------------------------
`default_nettype none

package hup_pkg;

    localparam int unsigned HELD_LEN   = 11;
    localparam int unsigned FILL_W     = 4;
    localparam int unsigned DIGITS     = 8;
    localparam int unsigned UID_W      = 32;
    localparam int unsigned COUNT_W    = 32;

    localparam logic [7:0] SYM_START = 8'h02;
    localparam logic [7:0] SYM_END   = 8'h03;
    localparam logic [7:0] SYM_CR    = 8'h0D;
    localparam logic [7:0] SYM_LF    = 8'h0A;

    // Kind of an input item, carried on the slave-side tuser.
    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HELD_LEN);

    // Status of the byte held in one cell of the window.
    typedef struct packed {
        logic       is_start;
        logic       is_cr;
        logic       is_lf;
        logic       hex_ok;
        logic [3:0] nibble;
    } t_cell_info;

    // Decodes an ASCII hex digit; bit 4 is set when the byte is one.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            res = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            res = {1'b1, 4'(c - 8'h57)};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- sv/hup_cell.sv -----
// ----------------------------------------------------------------------------
// hup_cell: one byte position of the sliding window
// Holds a byte, hands it on to the older neighbour on every shift and
// reports what kind of symbol it holds.
// ----------------------------------------------------------------------------
`default_nettype none

module hup_cell (
    input  wire logic             i_clk,
    input  wire logic             i_shift_en,
    input  wire logic [7:0]       i_byte,
    output logic      [7:0]       o_byte,
    output hup_pkg::t_cell_info   o_info
);

    logic [7:0] r_byte;
    logic [4:0] nib;

    always_ff @(posedge i_clk) begin
        if (i_shift_en) begin
            r_byte <= i_byte;
        end
    end

    assign nib    = hup_pkg::nibble_of(r_byte);
    assign o_byte = r_byte;

    always_comb begin
        o_info.is_start = (r_byte == hup_pkg::SYM_START);
        o_info.is_cr    = (r_byte == hup_pkg::SYM_CR);
        o_info.is_lf    = (r_byte == hup_pkg::SYM_LF);
        o_info.hex_ok   = nib[4];
        o_info.nibble   = nib[3:0];
    end

endmodule

`default_nettype wire

// ----- sv/hex_uid_frame_parser_core.sv -----
// ----------------------------------------------------------------------------
// hex_uid_frame_parser_core: card-number frame parser
// Watches a stream of received bytes for a twelve-byte frame made of
// STX, eight ASCII hex digits, CR, LF, ETX and reports the card number.
// ----------------------------------------------------------------------------
// Usage.
// The slave channel takes one item per handshake: tdata carries the received
// byte and tuser says whether the item is a byte (0) or a flush (1), which
// empties the window after a pause on the line. The master channel gives one
// item for every complete, well-formed frame: the card number in the low word
// and the running read count, including this frame, in the high word.
// The window is a row of eleven byte cells that shift towards the oldest end
// on each received byte; the frame is checked against the cells and the
// incoming byte in the same cycle, so a result item appears on the master
// side in the cycle after the ETX is accepted. One item is accepted every
// cycle, limited only by the output register: while a result waits, a new
// item is still taken if the receiver takes the waiting one in that cycle.
// After reset the window is empty, the read count is zero and no result is
// pending. When the receiver stalls with a result pending, the slave side
// stops accepting until the result has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_uid_frame_parser_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Received items.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tuser,   // [0] action (1 = flush)
    // Result items.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [63:0] m_axis_tdata    // [31:0] card_uid, [63:32] read_count
);

    localparam int unsigned N = hup_pkg::HELD_LEN;

    // Cell row: index 0 holds the oldest byte, the new byte enters at N-1.
    logic [7:0]          cell_in   [N];
    logic [7:0]          cell_out  [N];
    hup_pkg::t_cell_info cell_info [N];

    logic in_acc;
    logic is_flush;
    logic shift_en;
    logic digits_ok;
    logic frame_hit;
    logic [hup_pkg::UID_W-1:0] uid;

    logic [hup_pkg::FILL_W-1:0]  r_fill,  n_fill;
    logic [hup_pkg::COUNT_W-1:0] r_count, n_count;
    logic                        r_out_valid, n_out_valid;
    logic [hup_pkg::UID_W-1:0]   r_out_uid;
    logic [hup_pkg::COUNT_W-1:0] r_out_count;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_flush      = (s_axis_tuser == hup_pkg::ACT_FLUSH);
    // The row shifts on every received byte; after a hit the fill count
    // drops to zero, so the shifted contents are never checked again.
    assign shift_en      = in_acc && !is_flush;

    for (genvar g = 0; g < N; g++) begin : g_cell
        if (g == N - 1) begin : g_head
            assign cell_in[g] = s_axis_tdata;
        end else begin : g_body
            assign cell_in[g] = cell_out[g+1];
        end
        hup_cell u_cell (
            .i_clk      (i_clk),
            .i_shift_en (shift_en),
            .i_byte     (cell_in[g]),
            .o_byte     (cell_out[g]),
            .o_info     (cell_info[g])
        );
    end

    // The eight digit cells sit between the STX cell and the CR cell; the
    // first digit received is the most significant nibble.
    always_comb begin
        digits_ok = 1'b1;
        uid       = '0;
        for (int k = 0; k < hup_pkg::DIGITS; k++) begin
            digits_ok = digits_ok && cell_info[k+1].hex_ok;
            uid[(hup_pkg::DIGITS-1-k)*4 +: 4] = cell_info[k+1].nibble;
        end
    end

    // A frame is only checked once eleven bytes are held, so that cells
    // still carrying stale bytes never take part.
    assign frame_hit = shift_en && (r_fill == hup_pkg::FILL_FULL)
                       && cell_info[0].is_start && digits_ok
                       && cell_info[N-2].is_cr && cell_info[N-1].is_lf
                       && (s_axis_tdata == hup_pkg::SYM_END);

    always_comb begin
        n_fill      = r_fill;
        n_count     = r_count;
        n_out_valid = r_out_valid && !m_axis_tready;
        if (in_acc) begin
            if (is_flush || frame_hit) begin
                n_fill = '0;
            end else if (r_fill != hup_pkg::FILL_FULL) begin
                n_fill = r_fill + 1'b1;
            end
        end
        if (frame_hit) begin
            n_count     = r_count + 1'b1;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_hit) begin
            r_out_uid   <= uid;
            r_out_count <= n_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_count, r_out_uid};

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= hup_pkg::FILL_FULL)
        else $error("window fill count beyond eleven");

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_flush) |=> (r_fill == '0))
        else $error("flush did not empty the window");

    a_hit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_hit |=> (r_out_valid && r_fill == '0 && r_out_count == r_count))
        else $error("frame hit did not produce a result");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count == r_count))
        else $error("pending read count differs from frame counter");
`endif

endmodule

`default_nettype wire

// ----- dv/hup_read_checker.sv -----
// ----------------------------------------------------------------------------
// hup_read_checker: result checker for the card-number frame parser
// Watches both streams of the parser, keeps its own copy of the byte window
// and read counter, and compares every result item with the oldest predicted
// card read.
// ----------------------------------------------------------------------------
module hup_read_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,      // [7:0] rx_byte
    input  wire logic        i_s_tuser,      // [0] action (1 = flush)
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [63:0] i_m_tdata,      // [31:0] card_uid, [63:32] read_count
    output int               o_fail_count,
    output int               o_reads_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [hup_pkg::UID_W-1:0]   uid;
        logic [hup_pkg::COUNT_W-1:0] count;
    } t_card_read;

    logic [7:0]                  held [hup_pkg::HELD_LEN];
    logic [hup_pkg::FILL_W-1:0]  held_fill;
    logic [hup_pkg::COUNT_W-1:0] reads_seen;
    t_card_read                  pending_reads [$];
    int                          fails;

    // Value of an ASCII hex digit, or -1 for any other byte.
    function automatic int hex_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        return -1;
    endfunction

    task automatic clear_window();
        for (int i = 0; i < hup_pkg::HELD_LEN; i++) held[i] = 8'h00;
        held_fill = '0;
    endtask

    // Applies one accepted item to the window and records any card read.
    task automatic predict_card_read(input logic act, input logic [7:0] b);
        logic                      ok;
        logic [hup_pkg::UID_W-1:0] uid;
        int                        d;
        uid = '0;
        if (act == hup_pkg::ACT_FLUSH) begin
            clear_window();
        end else if (held_fill < hup_pkg::FILL_FULL) begin
            held[held_fill] = b;
            held_fill = held_fill + 1'b1;
        end else begin
            ok = held[0] == hup_pkg::SYM_START &&
                 held[hup_pkg::HELD_LEN-2] == hup_pkg::SYM_CR &&
                 held[hup_pkg::HELD_LEN-1] == hup_pkg::SYM_LF &&
                 b == hup_pkg::SYM_END;
            for (int i = 1; i <= hup_pkg::DIGITS; i++) begin
                d = hex_value(held[i]);
                if (d < 0) ok = 1'b0;
                uid = {uid[hup_pkg::UID_W-5:0], d[3:0]};
            end
            if (ok) begin
                reads_seen = reads_seen + 1'b1;
                pending_reads.push_back('{uid: uid, count: reads_seen});
                clear_window();
            end else begin
                for (int i = 0; i < hup_pkg::HELD_LEN - 1; i++) held[i] = held[i+1];
                held[hup_pkg::HELD_LEN-1] = b;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_card_read exp_read;
        if (!i_rst_n) begin
            clear_window();
            reads_seen = '0;
            pending_reads.delete();
            fails = 0;
        end else begin
            // The result of an item can only show up in a later cycle, so the
            // comparison is done before the new item is applied.
            if (i_m_tvalid && i_m_tready) begin
                if (pending_reads.size() == 0) begin
                    $error("unexpected result item: card_uid %h, read_count %h",
                           i_m_tdata[31:0], i_m_tdata[63:32]);
                    fails++;
                end else begin
                    exp_read = pending_reads.pop_front();
                    if (i_m_tdata[31:0] !== exp_read.uid) begin
                        $error("card_uid mismatch: expected %h, actual %h",
                               exp_read.uid, i_m_tdata[31:0]);
                        fails++;
                    end
                    if (i_m_tdata[63:32] !== exp_read.count) begin
                        $error("read_count mismatch: expected %h, actual %h",
                               exp_read.count, i_m_tdata[63:32]);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) predict_card_read(i_s_tuser, i_s_tdata);
        end
        o_fail_count    = fails;
        o_reads_pending = pending_reads.size();
    end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench of the card-number frame parser
// Feeds directed and random byte streams, mostly well-formed frames with
// random digits mixed with noise, broken frames and flushes, under random
// sender bursts and receiver stalls. A separate checker predicts and
// compares the card reads; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1750;
    localparam int PAUSE_EVERY    = 600;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int FRAME_BYTES    = 12;

    // Bytes just outside the ASCII hex digit ranges.
    localparam logic [5:0][7:0] NEAR_MISS = {8'h67, 8'h60, 8'h47, 8'h40, 8'h3A, 8'h2F};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tuser = hup_pkg::ACT_BYTE;
    logic        m_axis_tready = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [63:0] m_axis_tdata;
    int          fail_count;
    int          reads_pending;

    int          burst_left = 0;
    int          gap_len;
    int          items_sent = 0;
    int          next_pause = PAUSE_EVERY;
    int          idle_cycles = 0;
    int          stall_phase_left = 0;
    logic [15:0] stall_mask = 16'hFFFF;
    logic [FRAME_BYTES-1:0][7:0] frame;
    int          cut;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    hex_uid_frame_parser_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    hup_read_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_s_tuser       (s_axis_tuser),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_reads_pending (reads_pending)
    );

    // The receiver stalls following a rotating 16-bit mask that is redrawn
    // now and then. Bit 0 of each new mask is set, so no stall outlasts one turn
    // of the mask, and some phases take every result item at once.
    always @(negedge i_clk) begin
        if (stall_phase_left == 0) begin
            stall_phase_left = $urandom_range(20, 150);
            stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        end
        stall_phase_left--;
        m_axis_tready = stall_mask[0];
        stall_mask = {stall_mask[0], stall_mask[15:1]};
    end

    // Ends the run when neither channel has moved an item for too long.
    always @(posedge i_clk) begin
        if (i_rst_n && !((s_axis_tvalid && s_axis_tready) ||
                         (m_axis_tvalid && m_axis_tready))) begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

    // Offers one item at a falling edge and holds it until it is accepted.
    // Items go out in bursts of random length; about a third of the bursts
    // follow straight on from the previous one, the rest after a short gap.
    task automatic send_item(input logic act, input logic [7:0] b);
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap_len > 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap_len) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tuser  = act;
        s_axis_tdata  = b;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_bytes(input logic [FRAME_BYTES-1:0][7:0] f, input int count);
        for (int i = 0; i < count; i++) send_item(hup_pkg::ACT_BYTE, f[i]);
    endtask

    // Stops the sender until every predicted card read has come out.
    task automatic wait_reads_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (reads_pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] random_hex_char();
        int idx;
        idx = $urandom_range(0, 21);
        if (idx < 10) return 8'h30 + 8'(idx);
        if (idx < 16) return 8'h41 + 8'(idx - 10);
        return 8'h61 + 8'(idx - 16);
    endfunction

    // A well-formed frame with random digits, start symbol in byte 0.
    function automatic logic [FRAME_BYTES-1:0][7:0] random_frame();
        logic [FRAME_BYTES-1:0][7:0] f;
        f[0] = hup_pkg::SYM_START;
        for (int i = 1; i <= hup_pkg::DIGITS; i++) f[i] = random_hex_char();
        f[9]  = hup_pkg::SYM_CR;
        f[10] = hup_pkg::SYM_LF;
        f[11] = hup_pkg::SYM_END;
        return f;
    endfunction

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. A flush on the empty window, then a stray start
        // symbol in front of a frame whose digits span both ends of every
        // hex range: the first candidate fails and the frame behind it is
        // found once the window has slid by one byte.
        send_item(hup_pkg::ACT_FLUSH, 8'hFF);
        send_item(hup_pkg::ACT_BYTE, hup_pkg::SYM_START);
        send_bytes({hup_pkg::SYM_END, hup_pkg::SYM_LF, hup_pkg::SYM_CR,
                    8'h42, 8'h35, 8'h66, 8'h61, 8'h46, 8'h41, 8'h39, 8'h30,
                    hup_pkg::SYM_START}, FRAME_BYTES);
        // A partial frame with the extreme byte values, then a flush.
        send_item(hup_pkg::ACT_BYTE, hup_pkg::SYM_START);
        send_item(hup_pkg::ACT_BYTE, 8'hFF);
        send_item(hup_pkg::ACT_BYTE, 8'h00);
        send_item(hup_pkg::ACT_FLUSH, 8'h00);
        // A clean frame straight after the flush must still be found.
        send_bytes(random_frame(), FRAME_BYTES);
        wait_reads_drained();

        // Random part: mostly well-formed frames, with noise, corrupted
        // frames, flushes mid-frame and frames that restart inside others.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            frame = random_frame();
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    repeat ($urandom_range(0, 3)) send_item(hup_pkg::ACT_BYTE, 8'($urandom));
                    send_bytes(frame, FRAME_BYTES);
                end
                4: begin
                    frame[$urandom_range(0, FRAME_BYTES - 1)] = 8'($urandom);
                    send_bytes(frame, FRAME_BYTES);
                end
                5: begin
                    frame[$urandom_range(1, hup_pkg::DIGITS)] = NEAR_MISS[$urandom_range(0, 5)];
                    send_bytes(frame, FRAME_BYTES);
                end
                6: begin
                    repeat ($urandom_range(1, 8)) send_item(hup_pkg::ACT_BYTE, 8'($urandom));
                end
                7: begin
                    // Part of a frame, or a whole one, then a flush.
                    send_bytes(frame, $urandom_range(0, FRAME_BYTES));
                    send_item(hup_pkg::ACT_FLUSH, 8'($urandom));
                end
                default: begin
                    // A cut-off frame with a full frame starting inside it.
                    cut = $urandom_range(1, FRAME_BYTES - 1);
                    send_bytes(frame, cut);
                    send_bytes(random_frame(), FRAME_BYTES);
                end
            endcase
            if (items_sent >= next_pause) begin
                wait_reads_drained();
                next_pause += PAUSE_EVERY;
            end
        end

        wait_reads_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
